// ===== design/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg: shared types and constants for the complex-coefficient FIR
// Tap count, field widths, item kinds, MAC control struct and the
// round-and-saturate step from the 40-bit accumulator to Q15.
// ----------------------------------------------------------------------------
package cfir_pkg;

    localparam int TAPS   = 512;
    localparam int TAP_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int IDX_W  = 9;
    localparam int SMP_W  = 16;
    localparam int ACC_W  = 40;
    localparam int PROD_W = 2 * SMP_W;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_LOAD_I = 2'd1;
    localparam logic [1:0] MODE_LOAD_Q = 2'd2;

    typedef struct packed {
        logic clear;   // zero both accumulators
        logic step;    // a tap's addresses go to the memories this cycle
        logic live;    // the history entry for this tap has been written
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;    // products still on their way to the accumulators
    } mac_stat_t;

    // floor((acc + 2^15) / 2^16), clamped to the Q15 range
    function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]       biased;
        logic signed [ACC_W-16:0]    q;
        logic signed [SMP_W-1:0]     res;
        biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(32768);
        q      = biased[ACC_W:16];
        if (q > (ACC_W-15)'(32767))
            res = 16'sh7FFF;
        else if (q < -(ACC_W-15)'(32768))
            res = 16'sh8000;
        else
            res = q[SMP_W-1:0];
        return res;
    endfunction

endpackage

// ===== design/cfir_ram.sv =====
// ----------------------------------------------------------------------------
// cfir_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cfir_mac.sv =====
// ----------------------------------------------------------------------------
// cfir_mac: shared I/Q multiply-accumulate unit
// One sample times an I and a Q coefficient per step, products doubled to
// Q31 and summed into 40-bit wrapping accumulators; rounded Q15 outputs.
// ----------------------------------------------------------------------------
module cfir_mac (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfir_pkg::mac_ctrl_t         ctrl,
    input  logic signed [15:0]          x_rdata,
    input  logic signed [15:0]          ci_rdata,
    input  logic signed [15:0]          cq_rdata,
    output cfir_pkg::mac_stat_t         stat,
    output logic signed [15:0]          i_res,
    output logic signed [15:0]          q_res
);

    import cfir_pkg::*;

    logic                     step_d1_reg;
    logic                     live_d1_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_q_reg;
    logic signed [ACC_W-1:0]  acc_i_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;
    logic signed [SMP_W-1:0]  x_gated;

    // history entries never written read as zero
    assign x_gated = live_d1_reg ? x_rdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_d1_reg  <= 1'b0;
            live_d1_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            step_d1_reg  <= ctrl.step;
            live_d1_reg  <= ctrl.live;
            prod_vld_reg <= step_d1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_i_reg <= x_gated * ci_rdata;
        prod_q_reg <= x_gated * cq_rdata;
        if (ctrl.clear) begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end else if (prod_vld_reg) begin
            // products are signed; sign-extend before the doubling shift
            acc_i_reg <= acc_i_reg + (ACC_W'(prod_i_reg) <<< 1);
            acc_q_reg <= acc_q_reg + (ACC_W'(prod_q_reg) <<< 1);
        end
    end

    assign stat.busy = step_d1_reg | prod_vld_reg;
    assign i_res     = round_sat(acc_i_reg);
    assign q_res     = round_sat(acc_q_reg);

endmodule

// ===== design/complex_fir_iq_filter_unit.sv =====
// ----------------------------------------------------------------------------
// complex_fir_iq_filter_unit: real-input FIR with complex coefficients
// A sample's I/Q beat follows the MAC steps over all TAPS taps (ST_CALC), the
// pipeline drain (ST_DRAIN) and the result state (ST_FINISH); loads give none.
// Loads are taken one per cycle while idle; an accepted sample blocks the input
// until its beat is issued; an unaccepted earlier beat holds it in ST_FINISH.
// Reset clears control state; history reads as zero until written.
// ----------------------------------------------------------------------------
module complex_fir_iq_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // tap_index[8:0], value[24:9], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // i_out[15:0], q_out[31:16]
);

    import cfir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [TAP_W-1:0]  k_reg;
    logic [TAP_W-1:0]  rd_ptr_reg;
    logic [TAP_W-1:0]  wp_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    logic [1:0]        mode;
    logic [IDX_W-1:0]  tap_index;
    logic [SMP_W-1:0]  value;
    logic              accept;
    logic              accept_smp;
    logic              load_ok;
    logic              out_free;
    mac_ctrl_t         mac_ctrl;
    mac_stat_t         mac_stat;
    logic signed [SMP_W-1:0] x_rdata;
    logic signed [SMP_W-1:0] ci_rdata;
    logic signed [SMP_W-1:0] cq_rdata;
    logic signed [SMP_W-1:0] i_res;
    logic signed [SMP_W-1:0] q_res;

    assign mode      = s_tuser;
    assign tap_index = s_tdata[IDX_W-1:0];
    assign value     = s_tdata[IDX_W +: SMP_W];

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign accept_smp = accept & (mode == MODE_SAMPLE);
    assign load_ok    = (32'(tap_index) < TAPS);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign mac_ctrl.clear = accept_smp;
    assign mac_ctrl.step  = (state_reg == ST_CALC);
    assign mac_ctrl.live  = (FILL_W'(k_reg) < fill_reg);

    cfir_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_hist (
        .aclk  (aclk),
        .we    (accept_smp),
        .waddr (wp_reg),
        .wdata (value),
        .raddr (rd_ptr_reg),
        .rdata (x_rdata)
    );

    cfir_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_coef_i (
        .aclk  (aclk),
        .we    (accept && mode == MODE_LOAD_I && load_ok),
        .waddr (TAP_W'(tap_index)),
        .wdata (value),
        .raddr (k_reg),
        .rdata (ci_rdata)
    );

    cfir_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_coef_q (
        .aclk  (aclk),
        .we    (accept && mode == MODE_LOAD_Q && load_ok),
        .waddr (TAP_W'(tap_index)),
        .wdata (value),
        .raddr (k_reg),
        .rdata (cq_rdata)
    );

    cfir_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .x_rdata  (x_rdata),
        .ci_rdata (ci_rdata),
        .cq_rdata (cq_rdata),
        .stat     (mac_stat),
        .i_res    (i_res),
        .q_res    (q_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            rd_ptr_reg   <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept_smp) begin
                        // newest sample is tap 0; walk towards older ones
                        k_reg      <= '0;
                        rd_ptr_reg <= wp_reg;
                        wp_reg     <= (wp_reg == '0) ? TAP_W'(TAPS - 1) : wp_reg - 1'b1;
                        if (fill_reg != FILL_W'(TAPS))
                            fill_reg <= fill_reg + 1'b1;
                        state_reg  <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    k_reg      <= k_reg + 1'b1;
                    rd_ptr_reg <= (rd_ptr_reg == TAP_W'(TAPS - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    if (k_reg == TAP_W'(TAPS - 1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (!mac_stat.busy)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {q_res, i_res};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/complex_fir_iq_filter_unit_test.sv =====
// ----------------------------------------------------------------------------
// complex_fir_iq_filter_unit_test: self-checking bench for the I/Q FIR unit
// Loads both coefficient memories over the input stream, then drives samples.
// A scoreboard keeps its own sample ring and coefficient copies, and predicts
// each I/Q pair when the sample beat is accepted. Phases: full-scale I taps to
// push the 40-bit accumulator through its wrap, directed edge taps and samples,
// a long result back-pressure, then random traffic with random gaps on both
// sides.
// ----------------------------------------------------------------------------

class iq_result_tracker;

    logic signed [15:0] history [cfir_pkg::TAPS];
    logic signed [15:0] coef_i [cfir_pkg::TAPS];
    logic signed [15:0] coef_q [cfir_pkg::TAPS];
    logic [cfir_pkg::TAP_W-1:0] wr_ptr;
    logic [31:0] pending_iq [$];
    int errors;
    int results_seen;

    function new();
        foreach (history[k]) begin
            history[k] = '0;
            coef_i[k]  = '0;
            coef_q[k]  = '0;
        end
        wr_ptr       = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    // 2*x*c summed mod 2^40, then floor((acc + 2^15) / 2^16) clamped to Q15
    function logic signed [15:0] filtered(bit use_q);
        logic signed [39:0] acc;
        logic signed [31:0] prod;
        logic signed [40:0] biased;
        logic signed [24:0] scaled;
        logic [cfir_pkg::TAP_W-1:0] idx;
        acc = '0;
        idx = wr_ptr;
        for (int k = 0; k < cfir_pkg::TAPS; k++) begin
            prod = history[idx] * (use_q ? coef_q[k] : coef_i[k]);
            acc  = acc + {{7{prod[31]}}, prod, 1'b0};
            idx  = idx + 1'b1;
        end
        biased = {acc[39], acc} + 41'sd32768;
        scaled = biased[40:16];
        if (scaled > 25'sd32767)
            return 16'sh7FFF;
        if (scaled < -25'sd32768)
            return 16'sh8000;
        return scaled[15:0];
    endfunction

    function void take_item(logic [1:0] mode, logic [31:0] data);
        logic [cfir_pkg::IDX_W-1:0] index;
        logic signed [15:0] value;
        index = data[8:0];
        value = data[24:9];
        case (mode)
            cfir_pkg::MODE_LOAD_I: if (index < cfir_pkg::TAPS) coef_i[index] = value;
            cfir_pkg::MODE_LOAD_Q: if (index < cfir_pkg::TAPS) coef_q[index] = value;
            cfir_pkg::MODE_SAMPLE: begin
                history[wr_ptr] = value;
                pending_iq.push_back({filtered(1'b1), filtered(1'b0)});
                wr_ptr = wr_ptr - 1'b1;
            end
            default: ;
        endcase
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task match_output(logic [31:0] data);
        logic [31:0] want;
        if (pending_iq.size() == 0) begin
            report($sformatf("unexpected beat %h", data));
        end else begin
            want = pending_iq.pop_front();
            if (data[15:0] !== want[15:0])
                report($sformatf("i_out got %0d expected %0d",
                                 $signed(data[15:0]), $signed(want[15:0])));
            if (data[31:16] !== want[31:16])
                report($sformatf("q_out got %0d expected %0d",
                                 $signed(data[31:16]), $signed(want[31:16])));
        end
        results_seen++;
    endtask

endclass

module complex_fir_iq_filter_unit_test;

    import cfir_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int MAX_GAP      = 8;
    localparam int HOLD_CYCLES  = 3000;
    // watchdog limit on a stretch with no beat accepted on either side
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 40;
    localparam int WRAP_SAMPLES = 260;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit rx_hold = 1'b0;
    int quiet_cycles = 0;

    iq_result_tracker tracker;

    complex_fir_iq_filter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.take_item(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready)
            tracker.match_output(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [8:0] index,
                             input logic [15:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, value, index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_iq.size() != 0) @(posedge aclk);
        repeat (TAPS + 8) @(posedge aclk);
    endtask

    // mostly small taps so outputs stay off the rails, some full-range
    function automatic logic [15:0] pick_coef();
        logic signed [15:0] raw;
        raw = 16'($urandom);
        if ($urandom_range(0, 4) == 0)
            return raw;
        return raw >>> $urandom_range(4, 10);
    endfunction

    initial begin : result_sink
        int stall;
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid && !rx_hold) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int n_items;
        int pick;
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // full-scale I taps: doubled products are +2^31 each, so the I sum wraps at 256 samples
        for (int k = 0; k < TAPS; k++) begin
            send_item(MODE_LOAD_I, 9'(k), 16'h8000);
            send_item(MODE_LOAD_Q, 9'(k), pick_coef());
            if (k % 64 == 0)
                send_item(MODE_UNUSED, 9'($urandom), 16'($urandom));
        end
        tx_idle = 1'b0;
        for (int n = 0; n < WRAP_SAMPLES; n++)
            send_item(MODE_SAMPLE, 9'($urandom), 16'h8000);
        repeat (3) send_item(MODE_SAMPLE, 9'h1FF, 16'h7FFF);
        tx_idle = 1'b1;
        wait_drained();

        // edge taps and edge samples
        send_item(MODE_LOAD_I, 9'h000, 16'h7FFF);
        send_item(MODE_LOAD_Q, 9'h000, 16'h8000);
        send_item(MODE_LOAD_I, 9'h1FF, 16'h8000);
        send_item(MODE_LOAD_Q, 9'h1FF, 16'h7FFF);
        send_item(MODE_SAMPLE, 9'h000, 16'h7FFF);
        send_item(MODE_SAMPLE, 9'h1FF, 16'h8000);
        send_item(MODE_SAMPLE, 9'h155, 16'h0000);
        send_item(MODE_SAMPLE, 9'h0AA, 16'h0001);
        send_item(MODE_SAMPLE, 9'h000, 16'hFFFF);
        send_item(MODE_UNUSED, 9'h1FF, 16'hFFFF);
        send_item(MODE_SAMPLE, 9'h1FF, 16'h5555);
        send_item(MODE_LOAD_I, 9'h155, 16'h0001);
        send_item(MODE_LOAD_Q, 9'h0AA, 16'hFFFF);
        send_item(MODE_SAMPLE, 9'h000, 16'hAAAA);
        send_item(MODE_UNUSED, 9'h000, 16'h0000);
        send_item(MODE_SAMPLE, 9'h000, 16'h7FFF);
        send_item(MODE_SAMPLE, 9'h000, 16'h7FFF);
        wait_drained();

        // sink holds off while samples and loads keep coming
        rx_hold = 1'b1;
        for (int n = 0; n < 10; n++) begin
            if (n % 3 == 2)
                send_item(MODE_LOAD_I, 9'($urandom), pick_coef());
            else
                send_item(MODE_SAMPLE, 9'($urandom), 16'($urandom));
        end
        wait_drained();

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            if (n_items % 150 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_item(MODE_SAMPLE, 9'($urandom),
                          ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom));
                n_items++;
            end else if (pick < 92) begin
                send_item(pick[0] ? MODE_LOAD_I : MODE_LOAD_Q, 9'($urandom), pick_coef());
                n_items++;
            end else begin
                send_item(MODE_UNUSED, 9'($urandom), 16'($urandom));
            end
        end

        wait_drained();
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/cfir_pkg.sv
design/cfir_ram.sv
design/cfir_mac.sv
design/complex_fir_iq_filter_unit.sv
dv/complex_fir_iq_filter_unit_test.sv
